>>> sv/sbrc_pkg.sv
// Shared types and constants for the sprite blitter with run-length decode and clipping.
// No dependencies; used by every module of the block.
package sbrc_pkg;

   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned CLIP_BITS      = 11;
   localparam int unsigned SIZE_BITS      = 11;
   localparam int unsigned COUNT_BITS     = 10;

   // Configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_CLIP_LEFT   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CLIP_TOP    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CLIP_RIGHT  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CLIP_BOTTOM = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LINE_PITCH  = 3'd4;

   localparam logic [CLIP_BITS-1:0] CLIP_LEFT_RESET   = 11'd0;
   localparam logic [CLIP_BITS-1:0] CLIP_TOP_RESET    = 11'd0;
   localparam logic [CLIP_BITS-1:0] CLIP_RIGHT_RESET  = 11'd640;
   localparam logic [CLIP_BITS-1:0] CLIP_BOTTOM_RESET = 11'd480;
   localparam logic [CLIP_BITS-1:0] LINE_PITCH_RESET  = 11'd640;

   localparam logic [SIZE_BITS-1:0] MAX_SIZE = 11'd1024;

   // Run-length command bytes
   localparam logic [7:0] CMD_END = 8'hFF;
   localparam logic [7:0] CMD_ROW = 8'hC9;

   typedef enum logic [1:0] {
      PH_CMD   = 2'd0,
      PH_COUNT = 2'd1,
      PH_PIXEL = 2'd2
   } phase_type;

   typedef struct packed {
      logic [CLIP_BITS-1:0] left;
      logic [CLIP_BITS-1:0] top;
      logic [CLIP_BITS-1:0] right;
      logic [CLIP_BITS-1:0] bottom;
   } clip_type;

   // One decoded result on its way to the address stage
   typedef struct packed {
      logic                 done;
      logic                 pixel_valid;
      logic [CLIP_BITS-1:0] x;
      logic [CLIP_BITS-1:0] y;
      logic [7:0]           value;
   } pix_type;

   function automatic logic [SIZE_BITS-1:0] size_clamp(input logic [SIZE_BITS-1:0] s);
      logic [SIZE_BITS-1:0] r;
      r = s;
      if (s == '0) r = SIZE_BITS'(1);
      else if (s > MAX_SIZE) r = MAX_SIZE;
      return r;
   endfunction

endpackage

>>> sv/sbrc_decode.sv
// Sprite byte decoder: raw walk and run-length decode, cursor tracking and clip test.
// Holds the sprite state and a registered result slot. Depends on sbrc_pkg.
module sbrc_decode #(
   parameter int COORD_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic                                 start_req,
   input  logic                                 mode,
   input  logic                                 flip,
   input  logic [COORD_BITS-1:0]                origin_x,
   input  logic [COORD_BITS-1:0]                origin_y,
   input  logic [sbrc_pkg::SIZE_BITS-1:0]       sprite_width,
   input  logic [sbrc_pkg::SIZE_BITS-1:0]       sprite_height,
   input  logic [7:0]                           data_byte,
   input  sbrc_pkg::clip_type                   clip,
   input  logic                                 out_ready,
   output logic                                 out_valid,
   output sbrc_pkg::pix_type                    out_pix
);

   localparam int CUR  = COORD_BITS + 1;
   localparam int WIDE = CUR + 11;
   localparam int SB   = sbrc_pkg::SIZE_BITS;
   localparam int CB   = sbrc_pkg::COUNT_BITS;
   localparam logic signed [WIDE-1:0] CUR_HI = WIDE'((64'sd1 <<< (CUR - 1)) - 64'sd1);
   localparam logic signed [WIDE-1:0] CUR_LO = -CUR_HI - WIDE'(1);

   function automatic logic signed [WIDE-1:0] sx(input logic [CUR-1:0] v);
      return {{(WIDE-CUR){v[CUR-1]}}, v};
   endfunction

   function automatic logic signed [WIDE-1:0] zx(input logic [sbrc_pkg::CLIP_BITS-1:0] v);
      return {{(WIDE-sbrc_pkg::CLIP_BITS){1'b0}}, v};
   endfunction

   function automatic logic [CUR-1:0] sat(input logic signed [WIDE-1:0] v);
      logic signed [WIDE-1:0] r;
      r = v;
      if (v > CUR_HI) r = CUR_HI;
      else if (v < CUR_LO) r = CUR_LO;
      return r[CUR-1:0];
   endfunction

   logic                    busy_ff, busy_in;
   logic                    mode_ff, mode_in;
   logic                    mirror_ff, mirror_in;
   logic [SB-1:0]           width_ff, width_in;
   logic [SB-1:0]           height_ff, height_in;
   logic [CUR-1:0]          rs_ff, rs_in;
   logic [CUR-1:0]          cx_ff, cx_in;
   logic [CUR-1:0]          cy_ff, cy_in;
   sbrc_pkg::phase_type     phase_ff, phase_in;
   logic [7:0]              run_ff, run_in;
   logic [CB-1:0]           col_ff, col_in;
   logic [CB-1:0]           row_ff, row_in;
   logic                    out_valid_ff, out_valid_in;
   sbrc_pkg::pix_type       out_pix_ff, out_pix_in;

   // State as seen by the byte, after a start overlay
   logic                    e_busy, e_mode, e_mirror;
   logic [SB-1:0]           e_width, e_height;
   logic [CUR-1:0]          e_rs, e_cx, e_cy;
   sbrc_pkg::phase_type     e_phase;
   logic [7:0]              e_run;
   logic [CB-1:0]           e_col, e_row;

   logic signed [WIDE-1:0]  x_w, y_w, dir_w, row_start_w;
   logic                    in_clip;
   logic [SB-1:0]           col1, row1;
   logic                    raw_last;
   logic                    res_valid;
   sbrc_pkg::pix_type       res_pix;

   always_comb begin
      e_busy   = busy_ff;
      e_mode   = mode_ff;
      e_mirror = mirror_ff;
      e_width  = width_ff;
      e_height = height_ff;
      e_rs     = rs_ff;
      e_cx     = cx_ff;
      e_cy     = cy_ff;
      e_phase  = phase_ff;
      e_run    = run_ff;
      e_col    = col_ff;
      e_row    = row_ff;
      row_start_w = {{(WIDE-COORD_BITS){origin_x[COORD_BITS-1]}}, origin_x};
      if (flip) begin
         row_start_w = row_start_w
            + {{(WIDE-SB){1'b0}}, sbrc_pkg::size_clamp(sprite_width)} - WIDE'(1);
      end
      if (start_req) begin
         e_busy   = 1'b1;
         e_mode   = mode;
         e_mirror = flip;
         e_width  = sbrc_pkg::size_clamp(sprite_width);
         e_height = sbrc_pkg::size_clamp(sprite_height);
         e_rs     = sat(row_start_w);
         e_cx     = sat(row_start_w);
         e_cy     = {origin_y[COORD_BITS-1], origin_y};
         e_phase  = sbrc_pkg::PH_CMD;
         e_run    = '0;
         e_col    = '0;
         e_row    = '0;
      end
   end

   assign x_w   = sx(e_cx);
   assign y_w   = sx(e_cy);
   assign dir_w = e_mirror ? -WIDE'(1) : WIDE'(1);
   assign in_clip = (x_w >= zx(clip.left)) && (x_w < zx(clip.right))
                 && (y_w >= zx(clip.top)) && (y_w < zx(clip.bottom));
   assign col1 = {1'b0, e_col} + SB'(1);
   assign row1 = {1'b0, e_row} + SB'(1);
   assign raw_last = (col1 >= e_width) && (row1 >= e_height);

   always_comb begin
      busy_in   = busy_ff;
      mode_in   = mode_ff;
      mirror_in = mirror_ff;
      width_in  = width_ff;
      height_in = height_ff;
      rs_in     = rs_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      phase_in  = phase_ff;
      run_in    = run_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      res_valid = 1'b0;
      res_pix   = '0;
      if (accept) begin
         busy_in   = e_busy;
         mode_in   = e_mode;
         mirror_in = e_mirror;
         width_in  = e_width;
         height_in = e_height;
         rs_in     = e_rs;
         cx_in     = e_cx;
         cy_in     = e_cy;
         phase_in  = e_phase;
         run_in    = e_run;
         col_in    = e_col;
         row_in    = e_row;
         if (e_busy && !e_mode) begin
            // raw pixel walk
            if (col1 < e_width) begin
               col_in = CB'(col1);
               cx_in  = sat(x_w + dir_w);
            end else begin
               col_in = '0;
               if (!raw_last) row_in = CB'(row1);
               cx_in  = e_rs;
               cy_in  = sat(y_w + WIDE'(1));
            end
            if (raw_last) busy_in = 1'b0;
            res_pix.done = raw_last;
            if (data_byte != 8'd0 && in_clip) begin
               res_pix.pixel_valid = 1'b1;
               res_pix.x     = x_w[sbrc_pkg::CLIP_BITS-1:0];
               res_pix.y     = y_w[sbrc_pkg::CLIP_BITS-1:0];
               res_pix.value = data_byte;
            end
            res_valid = res_pix.pixel_valid || raw_last;
         end else if (e_busy) begin
            case (e_phase)
               sbrc_pkg::PH_CMD: begin
                  if (data_byte == sbrc_pkg::CMD_END) begin
                     busy_in      = 1'b0;
                     res_pix.done = 1'b1;
                     res_valid    = 1'b1;
                  end else if (data_byte == sbrc_pkg::CMD_ROW) begin
                     cy_in = sat(y_w + WIDE'(1));
                     cx_in = e_rs;
                  end else begin
                     if (e_mirror) cx_in = sat(x_w - {{(WIDE-8){1'b0}}, data_byte});
                     else          cx_in = sat(x_w + {{(WIDE-8){1'b0}}, data_byte});
                     phase_in = sbrc_pkg::PH_COUNT;
                  end
               end
               sbrc_pkg::PH_COUNT: begin
                  run_in   = data_byte;
                  phase_in = (data_byte != 8'd0) ? sbrc_pkg::PH_PIXEL : sbrc_pkg::PH_CMD;
               end
               sbrc_pkg::PH_PIXEL: begin
                  cx_in  = sat(x_w + dir_w);
                  run_in = e_run - 8'd1;
                  if (e_run == 8'd1) phase_in = sbrc_pkg::PH_CMD;
                  if (in_clip) begin
                     res_valid           = 1'b1;
                     res_pix.pixel_valid = 1'b1;
                     res_pix.x     = x_w[sbrc_pkg::CLIP_BITS-1:0];
                     res_pix.y     = y_w[sbrc_pkg::CLIP_BITS-1:0];
                     res_pix.value = data_byte;
                  end
               end
               default: begin
                  phase_in = sbrc_pkg::PH_CMD;
               end
            endcase
         end
      end
   end

   always_comb begin
      out_pix_in   = out_pix_ff;
      out_valid_in = out_valid_ff;
      if (accept) begin
         out_valid_in = res_valid;
         out_pix_in   = res_pix;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         mode_ff      <= 1'b0;
         mirror_ff    <= 1'b0;
         width_ff     <= SB'(1);
         height_ff    <= SB'(1);
         rs_ff        <= '0;
         cx_ff        <= '0;
         cy_ff        <= '0;
         phase_ff     <= sbrc_pkg::PH_CMD;
         run_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         mode_ff      <= mode_in;
         mirror_ff    <= mirror_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         rs_ff        <= rs_in;
         cx_ff        <= cx_in;
         cy_ff        <= cy_in;
         phase_ff     <= phase_in;
         run_ff       <= run_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_pix_ff <= out_pix_in;
   end

   assign out_valid = out_valid_ff;
   assign out_pix   = out_pix_ff;

   // Raw sprites never touch the run-length phase, so idle always means command phase
   a_idle_phase: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> phase_ff == sbrc_pkg::PH_CMD)
      else $error("decoder idle outside command phase");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !mode_ff |-> {1'b0, col_ff} < width_ff)
      else $error("raw column ran past sprite width");

   a_empty_is_done: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_pix_ff.pixel_valid |-> out_pix_ff.done
         && out_pix_ff.x == '0 && out_pix_ff.y == '0 && out_pix_ff.value == '0)
      else $error("result without pixel is not a clean sprite end");

endmodule

>>> sv/sbrc_addr.sv
// Address stage: frame address = row * line pitch + column, into the result register.
// Takes decoded pixels from sbrc_decode. Depends on sbrc_pkg.
module sbrc_addr #(
   parameter int ADDR_BITS = 22
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  sbrc_pkg::pix_type                    in_pix,
   input  logic [sbrc_pkg::CLIP_BITS-1:0]       line_pitch,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output sbrc_pkg::pix_type                    out_pix,
   output logic [ADDR_BITS-1:0]                 out_address
);

   localparam int CB       = sbrc_pkg::CLIP_BITS;
   localparam int SUM_BITS = (ADDR_BITS > 2 * CB + 1) ? ADDR_BITS : 2 * CB + 1;

   logic                  valid_ff, valid_in;
   sbrc_pkg::pix_type     pix_ff, pix_in;
   logic [ADDR_BITS-1:0]  addr_ff, addr_in;
   logic [2*CB-1:0]       product;
   logic [SUM_BITS-1:0]   sum;
   logic                  take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;
   assign product  = in_pix.y * line_pitch;
   assign sum      = SUM_BITS'(product) + SUM_BITS'(in_pix.x);

   always_comb begin
      valid_in = valid_ff;
      pix_in   = pix_ff;
      addr_in  = addr_ff;
      if (take) begin
         valid_in = 1'b1;
         pix_in   = in_pix;
         addr_in  = sum[ADDR_BITS-1:0];
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      pix_ff  <= pix_in;
      addr_ff <= addr_in;
   end

   assign out_valid   = valid_ff;
   assign out_pix     = pix_ff;
   assign out_address = addr_ff;

   a_no_pixel_addr: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !pix_ff.pixel_valid |-> addr_ff == '0)
      else $error("address set on a result without pixel");

   a_load_from_input: assert property (@(posedge clock) disable iff (reset)
      take |=> valid_ff && pix_ff == $past(in_pix))
      else $error("address stage lost a transaction");

endmodule

>>> sv/sprite_blitter_rle_clip_unit.sv
// Sprite blitter, raw or run-length coded, with exact per-pixel clipping. One sprite
// byte is taken per clock and never stalls the input unless the result side holds two
// results back; a pixel passes from its byte to the result port through one
// register for cursor update and clip test, one for the row * pitch multiply and add.
// A byte with the start flag in tuser begins a sprite and is itself the first data byte.
// Depends on sbrc_pkg, sbrc_decode and sbrc_addr.
module sprite_blitter_rle_clip_unit #(
   parameter int COORD_BITS = 12,
   parameter int ADDR_BITS  = 22
) (
   input  logic clock,
   input  logic reset,
   // flip, origin_x, origin_y, sprite_width, sprite_height, data_byte (low bit up)
   input  logic [((2 * COORD_BITS + 31 + 7) / 8) * 8 - 1:0] req_tdata,
   // start_req, mode (low bit up)
   input  logic [1:0]                                      req_tuser,
   input  logic                                            req_tvalid,
   output logic                                            req_tready,
   // pixel_x, pixel_y, pixel_address, pixel_value (low bit up)
   output logic [((ADDR_BITS + 30 + 7) / 8) * 8 - 1:0]     rsp_tdata,
   // pixel_valid
   output logic                                            rsp_tuser,
   // sprite_done
   output logic                                            rsp_tlast,
   output logic                                            rsp_tvalid,
   input  logic                                            rsp_tready,
   input  logic                                            csr_valid,
   output logic                                            csr_ready,
   input  logic [sbrc_pkg::CSR_INDEX_BITS-1:0]             csr_index,
   input  logic [sbrc_pkg::CLIP_BITS-1:0]                  csr_data
);

   localparam int CB        = sbrc_pkg::CLIP_BITS;
   localparam int SB        = sbrc_pkg::SIZE_BITS;
   localparam int OUT_BITS  = ((ADDR_BITS + 30 + 7) / 8) * 8;
   localparam int OUT_USED  = ADDR_BITS + 30;
   localparam int OX_LO     = 1;
   localparam int OY_LO     = OX_LO + COORD_BITS;
   localparam int W_LO      = OY_LO + COORD_BITS;
   localparam int H_LO      = W_LO + SB;
   localparam int B_LO      = H_LO + SB;

   sbrc_pkg::clip_type    clip_ff, clip_in;
   logic [CB-1:0]         pitch_ff, pitch_in;
   logic                  csr_take;
   logic                  req_take;
   logic                  dec_valid;
   logic                  addr_ready;
   sbrc_pkg::pix_type     dec_pix;
   sbrc_pkg::pix_type     rsp_pix;
   logic [ADDR_BITS-1:0]  rsp_address;

   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;

   always_comb begin
      clip_in  = clip_ff;
      pitch_in = pitch_ff;
      if (csr_take) begin
         case (csr_index)
            sbrc_pkg::REG_CLIP_LEFT:   clip_in.left   = csr_data;
            sbrc_pkg::REG_CLIP_TOP:    clip_in.top    = csr_data;
            sbrc_pkg::REG_CLIP_RIGHT:  clip_in.right  = csr_data;
            sbrc_pkg::REG_CLIP_BOTTOM: clip_in.bottom = csr_data;
            sbrc_pkg::REG_LINE_PITCH:  pitch_in       = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_ff.left   <= sbrc_pkg::CLIP_LEFT_RESET;
         clip_ff.top    <= sbrc_pkg::CLIP_TOP_RESET;
         clip_ff.right  <= sbrc_pkg::CLIP_RIGHT_RESET;
         clip_ff.bottom <= sbrc_pkg::CLIP_BOTTOM_RESET;
         pitch_ff       <= sbrc_pkg::LINE_PITCH_RESET;
      end else begin
         clip_ff  <= clip_in;
         pitch_ff <= pitch_in;
      end
   end

   // Decoder slot is free when empty or draining into the address stage
   assign req_tready = !dec_valid || addr_ready;
   assign req_take   = req_tvalid && req_tready;

   sbrc_decode #(
      .COORD_BITS (COORD_BITS)
   ) u_decode (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_take),
      .start_req     (req_tuser[0]),
      .mode          (req_tuser[1]),
      .flip          (req_tdata[0]),
      .origin_x      (req_tdata[OX_LO +: COORD_BITS]),
      .origin_y      (req_tdata[OY_LO +: COORD_BITS]),
      .sprite_width  (req_tdata[W_LO +: SB]),
      .sprite_height (req_tdata[H_LO +: SB]),
      .data_byte     (req_tdata[B_LO +: 8]),
      .clip          (clip_ff),
      .out_ready     (addr_ready),
      .out_valid     (dec_valid),
      .out_pix       (dec_pix)
   );

   sbrc_addr #(
      .ADDR_BITS (ADDR_BITS)
   ) u_addr (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (dec_valid),
      .in_ready    (addr_ready),
      .in_pix      (dec_pix),
      .line_pitch  (pitch_ff),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_pix     (rsp_pix),
      .out_address (rsp_address)
   );

   assign rsp_tdata = {{(OUT_BITS - OUT_USED){1'b0}},
                       rsp_pix.value, rsp_address, rsp_pix.y, rsp_pix.x};
   assign rsp_tuser = rsp_pix.pixel_valid;
   assign rsp_tlast = rsp_pix.done;

endmodule

>>> test/tb_sprite_blitter_rle_clip_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for sprite_blitter_rle_clip_unit: raw and run-length sprites
// streamed through a clocked driver/monitor pair and checked against an in-line predictor.
// Depends on sbrc_pkg and the sprite_blitter_rle_clip_unit RTL.
module tb_sprite_blitter_rle_clip_unit;

   localparam int REQ_BITS       = ((2 * 12 + 31 + 7) / 8) * 8;
   localparam int RSP_BITS       = ((22 + 30 + 7) / 8) * 8;
   localparam int SIZE_LIMIT     = 1024;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_CYCLES    = 80;
   localparam int WATCHDOG_LIMIT = 1000;

   typedef struct packed {
      logic        start;
      logic        mode;
      logic        flip;
      logic [11:0] ox;
      logic [11:0] oy;
      logic [10:0] w;
      logic [10:0] h;
      logic [7:0]  data;
   } sprite_byte_type;

   typedef struct packed {
      logic        pixel_valid;
      logic [10:0] x;
      logic [10:0] y;
      logic [21:0] addr;
      logic [7:0]  value;
      logic        done;
   } blit_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sprite_byte_type                       drv_item = '0;
   logic [REQ_BITS-1:0]                   req_tdata;
   logic [1:0]                            req_tuser;
   logic                                  req_tvalid = 1'b0;
   logic                                  req_tready;
   logic [RSP_BITS-1:0]                   rsp_tdata;
   logic                                  rsp_tuser;
   logic                                  rsp_tlast;
   logic                                  rsp_tvalid;
   logic                                  rsp_tready = 1'b0;
   logic                                  csr_valid = 1'b0;
   logic                                  csr_ready;
   logic [sbrc_pkg::CSR_INDEX_BITS-1:0]   csr_index = '0;
   logic [sbrc_pkg::CLIP_BITS-1:0]        csr_data = '0;

   // flip, origin_x, origin_y, sprite_width, sprite_height, data_byte (low bit up)
   assign req_tdata = {1'b0, drv_item.data, drv_item.h, drv_item.w, drv_item.oy,
                       drv_item.ox, drv_item.flip};
   // start_req, mode (low bit up)
   assign req_tuser = {drv_item.mode, drv_item.start};

   sprite_blitter_rle_clip_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor state
   int cfg_left = 0, cfg_top = 0, cfg_right = 640, cfg_bottom = 480, cfg_pitch = 640;

   bit                  rle_mode = 1'b0, mirrored = 1'b0, drawing = 1'b0;
   int                  cur_x = 0, cur_y = 0, row_x = 0;
   sbrc_pkg::phase_type rle_phase = sbrc_pkg::PH_CMD;
   int                  run_left = 0, raw_col = 0, raw_row = 0;
   int                  width_eff = 1, height_eff = 1;

   sprite_byte_type byte_q[$];
   blit_result_type pixel_q[$];
   int              n_queued = 0, n_taken = 0, mismatches = 0;
   bit              req_fire = 1'b0;
   bit              quiet = 1'b0;
   int              hold_requests = 0, holds_done = 0;
   int              idle_cycles = 0;

   function automatic int size_limit(input logic [10:0] s);
      if (s == 0) return 1;
      if (s > SIZE_LIMIT) return SIZE_LIMIT;
      return int'(s);
   endfunction

   // cursors are 13-bit signed and stick at their limits
   function automatic int sat_cursor(input longint v);
      if (v > 4095) return 4095;
      if (v < -4096) return -4096;
      return int'(v);
   endfunction

   function automatic bit in_clip(input int x, input int y);
      return x >= cfg_left && x < cfg_right && y >= cfg_top && y < cfg_bottom;
   endfunction

   task automatic blit_byte(input sprite_byte_type it);
      int x, y, dir, ox, oy;
      bit last, draw, emit;
      longint a;
      blit_result_type r;
      r = '0;
      emit = 1'b0;
      draw = 1'b0;
      if (it.start) begin
         ox = int'($signed(it.ox));
         oy = int'($signed(it.oy));
         rle_mode = it.mode;
         mirrored = it.flip;
         width_eff = size_limit(it.w);
         height_eff = size_limit(it.h);
         row_x = sat_cursor(ox + (mirrored ? width_eff - 1 : 0));
         cur_x = row_x;
         cur_y = oy;
         rle_phase = sbrc_pkg::PH_CMD;
         run_left = 0;
         raw_col = 0;
         raw_row = 0;
         drawing = 1'b1;
      end
      if (!drawing) return;
      dir = mirrored ? -1 : 1;
      x = cur_x;
      y = cur_y;
      if (!rle_mode) begin
         last = raw_col + 1 >= width_eff && raw_row + 1 >= height_eff;
         draw = it.data != 0 && in_clip(x, y);
         if (raw_col + 1 < width_eff) begin
            raw_col++;
            cur_x = sat_cursor(cur_x + dir);
         end else begin
            raw_col = 0;
            if (!last) raw_row = (raw_row + 1) & 'h3FF;
            cur_x = row_x;
            cur_y = sat_cursor(cur_y + 1);
         end
         if (last) drawing = 1'b0;
         r.done = last;
         emit = draw || last;
      end else begin
         case (rle_phase)
            sbrc_pkg::PH_CMD: begin
               if (it.data == sbrc_pkg::CMD_END) begin
                  drawing = 1'b0;
                  r.done = 1'b1;
                  emit = 1'b1;
               end else if (it.data == sbrc_pkg::CMD_ROW) begin
                  cur_y = sat_cursor(cur_y + 1);
                  cur_x = row_x;
               end else begin
                  cur_x = sat_cursor(cur_x + dir * int'(it.data));
                  rle_phase = sbrc_pkg::PH_COUNT;
               end
            end
            sbrc_pkg::PH_COUNT: begin
               run_left = int'(it.data);
               rle_phase = (it.data != 0) ? sbrc_pkg::PH_PIXEL : sbrc_pkg::PH_CMD;
            end
            default: begin
               draw = in_clip(x, y);
               cur_x = sat_cursor(cur_x + dir);
               run_left = (run_left - 1) & 'hFF;
               if (run_left == 0) rle_phase = sbrc_pkg::PH_CMD;
               emit = draw;
            end
         endcase
      end
      if (draw) begin
         a = longint'(y) * cfg_pitch + x;
         r.pixel_valid = 1'b1;
         r.x = x[10:0];
         r.y = y[10:0];
         r.addr = a[21:0];
         r.value = it.data;
      end
      if (emit) pixel_q.push_back(r);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   // ---------------------------------------------------------------- driver / receiver
   int gap_left = 0;
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_fire)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (byte_q.size() != 0) begin
            drv_item <= byte_q.pop_front();
            req_tvalid <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 4);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   int stall_left = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (holds_done != hold_requests) begin
            // long hold-off so the block backs up into its input
            holds_done++;
            stall_left = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin : monitor
      blit_result_type want;
      if (reset) begin
         req_fire <= 1'b0;
         idle_cycles = 0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            blit_byte(drv_item);
            n_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pixel_q.size() == 0) begin
               $error("unexpected result transaction: tdata 0x%0h", rsp_tdata);
               mismatches++;
            end else begin
               want = pixel_q.pop_front();
               check_field("pixel_valid", 32'(want.pixel_valid), 32'(rsp_tuser));
               check_field("pixel_x", 32'(want.x), 32'(rsp_tdata[10:0]));
               check_field("pixel_y", 32'(want.y), 32'(rsp_tdata[21:11]));
               check_field("pixel_address", 32'(want.addr), 32'(rsp_tdata[43:22]));
               check_field("pixel_value", 32'(want.value), 32'(rsp_tdata[51:44]));
               check_field("sprite_done", 32'(want.done), 32'(rsp_tlast));
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("sprite_blitter_rle_clip_unit test failed");
               $finish;
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   task automatic push_byte(input bit start, input bit mode, input bit flip, input int ox,
                            input int oy, input int w, input int h, input int data);
      sprite_byte_type it;
      it.start = start;
      it.mode = mode;
      it.flip = flip;
      it.ox = ox[11:0];
      it.oy = oy[11:0];
      it.w = w[10:0];
      it.h = h[10:0];
      it.data = data[7:0];
      byte_q.push_back(it);
      n_queued++;
   endtask

   // continuation byte; the fields read only on start carry junk
   task automatic push_data(input int data);
      push_byte(1'b0, 1'($urandom), 1'($urandom), $urandom, $urandom, $urandom, $urandom,
                data);
   endtask

   function automatic int pick_coord(input int lo, input int hi);
      int v;
      if ($urandom_range(0, 9) == 0) v = int'($urandom_range(0, 4095)) - 2048;
      else if (hi > lo) v = lo - 8 + int'($urandom_range(0, hi - lo + 8));
      else v = int'($urandom_range(0, 700));
      if (v > 2047) v = 2047;
      return v;
   endfunction

   task automatic gen_raw_sprite();
      int w, h, n, px;
      bit flip;
      case ($urandom_range(0, 19))
         0: begin
            w = $urandom_range(0, 2047);
            h = $urandom_range(0, 2047);
         end
         1, 2: begin
            w = $urandom_range(9, 40);
            h = $urandom_range(1, 2);
         end
         default: begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 5);
         end
      endcase
      flip = 1'($urandom_range(0, 1));
      n = size_limit(11'(w)) * size_limit(11'(h));
      // oversized or occasionally cut short: abandoned by the next start
      if (n > 40 || $urandom_range(0, 7) == 0) n = $urandom_range(1, n > 40 ? 40 : n);
      for (int i = 0; i < n; i++) begin
         px = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 255);
         if (i == 0)
            push_byte(1'b1, 1'b0, flip, pick_coord(cfg_left, cfg_right),
                      pick_coord(cfg_top, cfg_bottom), w, h, px);
         else
            push_data(px);
      end
   endtask

   task automatic gen_rle_sprite();
      int seq[$];
      int w, rows, segs, cnt, skip;
      bit flip;
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 40);
      flip = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 14))
         0: begin
            // long skips drive the cursor into saturation
            repeat (20) begin
               seq.push_back(8'hFE);
               seq.push_back(0);
            end
            seq.push_back(1);
            seq.push_back(3);
            repeat (3) seq.push_back($urandom_range(1, 255));
         end
         1: repeat ($urandom_range(10, 60)) seq.push_back(int'(sbrc_pkg::CMD_ROW));
         default: ;
      endcase
      rows = $urandom_range(1, 4);
      for (int r = 0; r < rows; r++) begin
         if (r > 0) seq.push_back(int'(sbrc_pkg::CMD_ROW));
         segs = $urandom_range(0, 3);
         repeat (segs) begin
            skip = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 254) : $urandom_range(0, 8);
            if (skip == int'(sbrc_pkg::CMD_ROW)) skip--;
            seq.push_back(skip);
            cnt = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 6);
            seq.push_back(cnt);
            repeat (cnt) seq.push_back($urandom_range(0, 255));
         end
      end
      if (seq.size() == 0 || $urandom_range(0, 9) != 0) seq.push_back(int'(sbrc_pkg::CMD_END));
      push_byte(1'b1, 1'b1, flip, pick_coord(cfg_left, cfg_right),
                pick_coord(cfg_top, cfg_bottom), w, $urandom_range(0, 2047), seq[0]);
      for (int i = 1; i < seq.size(); i++) push_data(seq[i]);
   endtask

   task automatic gen_noise();
      if ($urandom_range(0, 2) == 0)
         push_byte(1'b1, 1'($urandom), 1'($urandom), $urandom_range(0, 4095),
                   $urandom_range(0, 4095), $urandom_range(0, 2047), $urandom_range(0, 2047),
                   $urandom_range(0, 255));
      repeat ($urandom_range(1, 6)) push_data($urandom_range(0, 255));
   endtask

   task automatic fill_random(input int budget);
      int target;
      int pick;
      target = n_queued + budget;
      while (n_queued < target) begin
         pick = $urandom_range(0, 19);
         if (pick < 9) gen_raw_sprite();
         else if (pick < 17) gen_rle_sprite();
         else gen_noise();
      end
   endtask

   task automatic wait_idle();
      while (n_taken != n_queued || pixel_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [sbrc_pkg::CSR_INDEX_BITS-1:0] idx, input int val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val[10:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         sbrc_pkg::REG_CLIP_LEFT:   cfg_left = val & 'h7FF;
         sbrc_pkg::REG_CLIP_TOP:    cfg_top = val & 'h7FF;
         sbrc_pkg::REG_CLIP_RIGHT:  cfg_right = val & 'h7FF;
         sbrc_pkg::REG_CLIP_BOTTOM: cfg_bottom = val & 'h7FF;
         sbrc_pkg::REG_LINE_PITCH:  cfg_pitch = val & 'h7FF;
         default: ;
      endcase
   endtask

   task automatic set_window(input int l, input int t, input int r, input int b,
                             input int p);
      csr_write(sbrc_pkg::REG_CLIP_LEFT, l);
      csr_write(sbrc_pkg::REG_CLIP_TOP, t);
      csr_write(sbrc_pkg::REG_CLIP_RIGHT, r);
      csr_write(sbrc_pkg::REG_CLIP_BOTTOM, b);
      csr_write(sbrc_pkg::REG_LINE_PITCH, p);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset window 0..640 x 0..480, pitch 640
      push_byte(1, 0, 0, 0, 0, 1, 1, 8'h00);          // lone transparent pixel ends sprite
      push_byte(1, 0, 0, 0, 0, 1, 1, 8'hFF);
      push_data(8'h55);                               // idle, ignored
      push_byte(1, 0, 1, -5, -5, 0, 0, 8'h07);        // zero size, clipped
      push_byte(1, 0, 1, 638, 478, 2, 2, 1);          // mirrored, fits the bottom-right corner
      push_data(2);
      push_data(3);
      push_data(0);
      push_byte(1, 1, 1, 100, 10, 3, 1, 0);           // mirrored run-length
      push_data(2);
      push_data(8'h00);                               // zero pixel still drawn
      push_data(8'hFF);
      push_data(int'(sbrc_pkg::CMD_ROW));
      push_data(1);
      push_data(0);                                   // zero count
      push_data(int'(sbrc_pkg::CMD_END));
      push_byte(1, 0, 0, 2047, -2048, 2047, 1500, 5); // oversize, then restarted
      push_data(6);
      push_byte(1, 1, 0, 0, 0, 1, 1, int'(sbrc_pkg::CMD_END));
      wait_idle();

      fill_random(300);
      while (n_taken < n_queued - 200) @(posedge clock);
      hold_requests++;
      wait_idle();

      set_window(10, 5, 40, 30, 2047);
      fill_random(300);
      wait_idle();

      set_window(0, 0, 2047, 2047, 1);
      fill_random(300);
      wait_idle();

      // inverted window hides everything
      set_window(2047, 2047, 0, 0, $urandom_range(1, 2047));
      fill_random(150);
      wait_idle();

      set_window($urandom_range(0, 1000), $urandom_range(0, 1000), $urandom_range(0, 2047),
                 $urandom_range(0, 2047), $urandom_range(1, 2047));
      fill_random(300);
      wait_idle();

      quiet = 1'b1;
      set_window(int'(sbrc_pkg::CLIP_LEFT_RESET), int'(sbrc_pkg::CLIP_TOP_RESET),
                 int'(sbrc_pkg::CLIP_RIGHT_RESET), int'(sbrc_pkg::CLIP_BOTTOM_RESET),
                 int'(sbrc_pkg::LINE_PITCH_RESET));
      fill_random(300);
      wait_idle();

      if (mismatches == 0 && pixel_q.size() == 0)
         $display("sprite_blitter_rle_clip_unit test passed");
      else
         $display("sprite_blitter_rle_clip_unit test failed");
      $finish;
   end

endmodule
